// ===== rtl/sitra_pkg.sv =====
// Shared types, constants and the digit-to-character function for the
// signed integer to radix text converter. No dependencies.
`default_nettype none

package sitra_pkg;

    // Default magnitude width and the fixed width of the value field
    localparam int VALUE_BITS_DEF = 32;
    localparam int VALUE_W_DEF    = 32;

    // Quotient bits the divider resolves per cycle
    localparam int STEP_BITS = 8;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Map a digit value 0..35 to '0'..'9', 'a'..'z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_TEN) begin
            ch = CHAR_ZERO + {2'b00, d};
        end
        else begin
            ch = CHAR_LOW_A + {2'b00, d - DIGIT_TEN};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sitra_if.sv =====
// Request channel interfaces for the radix text converter: the value input
// and the character output. Depends on sitra_pkg.
`default_nettype none

interface sitra_in_if #(
    parameter int VALUE_W = sitra_pkg::VALUE_W_DEF
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitra_out_if;
    logic                        valid;
    logic                        ready;
    logic [sitra_pkg::CHAR_W-1:0] char_code;
    logic                        last;
    logic                        empty_res;

    modport source (output valid, output char_code, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input char_code, input last, input empty_res,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/signed_integer_to_radix_ascii.sv =====
// Top level of the signed integer to radix text converter: sequencer, digit
// memory and output register. Depends on sitra_pkg, sitra_if and sitra_div.
//
// Takes one signed value per request and returns its text in the radix held
// by the radix register (2..36), one ASCII character per output request, most
// significant first, with a leading '-' for negative values; last marks the
// final character. An out-of-range radix gives a single request with
// empty_res and last set and char_code zero. The value's magnitude is divided
// by the radix in a shared iterative divider that resolves 8 quotient bits a
// cycle; the digits go to a small synchronous memory and are read back in
// reverse, one character per cycle while the output is not stalled. A new
// value is accepted once the last character sits in the output register. No
// clearing pass is needed after reset. The input port must be at least
// VALUE_BITS wide; only its low VALUE_BITS bits are used.
`default_nettype none

module signed_integer_to_radix_ascii #(
    parameter int VALUE_BITS = sitra_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [sitra_pkg::RADIX_W-1:0] cfg_wdata,
    sitra_in_if.sink                           in,
    sitra_out_if.source                        out
);
    import sitra_pkg::*;

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic               neg_reg, neg_next;
    logic               sign_reg, sign_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic                  radix_ok;
    logic                  out_free;
    logic                  out_load;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    div_status_t           div_st;
    logic [VALUE_BITS-1:0] div_q;
    logic [RADIX_W-1:0]    div_rem;

    logic                  mem_we;
    logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];
    logic [RADIX_W-1:0]    rd_data_reg;

    assign radix_ok = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign out_free = !out_valid_reg || out.ready;
    assign raw      = in.value[VALUE_BITS-1:0];
    assign mag      = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    // Feed the magnitude on a new request, else the running quotient
    assign div_dividend = (state_reg == ST_IDLE) ? mag : div_q;

    sitra_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_reg),
        .status    (div_st),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // Sequence division, readback and output
    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        sign_next      = sign_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in.valid) begin
                    if (radix_ok) begin
                        neg_next   = raw[VALUE_BITS-1];
                        cnt_next   = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else begin
                        state_next = ST_EMPTY;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_inc;
                    if ((div_q == '0) || (cnt_inc == CNT_W'(VALUE_BITS))) begin
                        state_next = ST_PREP;
                    end
                    else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                idx_next   = cnt_dec[IDX_W-1:0];
                sign_next  = neg_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_empty_next = 1'b0;
                    if (sign_reg) begin
                        out_char_next = CHAR_MINUS;
                        out_last_next = 1'b0;
                        sign_next     = 1'b0;
                    end
                    else begin
                        out_char_next = digit_char(rd_data_reg);
                        out_last_next = (idx_reg == '0);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end
                        else begin
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_char_next  = CHAR_NONE;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out.ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold state, radix and the output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            neg_reg       <= 1'b0;
            sign_reg      <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end
            neg_reg       <= neg_next;
            sign_reg      <= sign_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
        end
    end

    // Write each finished digit; read ahead at the next index
    always_ff @(posedge clk) begin
        if (mem_we) begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= div_rem;
        end
        rd_data_reg <= digit_mem[idx_next];
    end

    assign in.ready      = (state_reg == ST_IDLE);
    assign out.valid     = out_valid_reg;
    assign out.char_code = out_char_reg;
    assign out.last      = out_last_reg;
    assign out.empty_res = out_empty_reg;

`ifndef SYNTHESIS
    // Never restart the divider while it is still working
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    // Digit writes stay inside the memory
    a_mem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (cnt_reg < CNT_W'(VALUE_BITS)))
        else $error("digit write beyond memory depth");

    // An empty result is a lone, final, zero character
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.empty_res) |-> (out.last && (out.char_code == CHAR_NONE)))
        else $error("malformed empty result");

    // Loading the final character frees the input
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after final character");

    // Readback never starts with no digits stored
    a_prep_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> (cnt_reg != '0))
        else $error("readback with empty digit memory");
`endif

endmodule

`default_nettype wire

// ===== rtl/sitra_div.sv =====
// Iterative divider by the radix: resolves STEP_BITS quotient bits a cycle
// by restoring long division. Depends on sitra_pkg.
`default_nettype none

module sitra_div #(
    parameter int VALUE_BITS = sitra_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [VALUE_BITS-1:0]         dividend,
    input  wire logic [sitra_pkg::RADIX_W-1:0] radix,
    output sitra_pkg::div_status_t             status,
    output logic [VALUE_BITS-1:0]              quotient,
    output logic [sitra_pkg::RADIX_W-1:0]      remainder
);
    import sitra_pkg::*;

    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;
    localparam int CYC_W      = $clog2(DIV_CYCLES + 1);

    logic [PAD_BITS-1:0] work_reg, work_next;
    logic [RADIX_W-1:0]  rem_reg, rem_next;
    logic [CYC_W-1:0]    cyc_reg;
    logic                done_reg;

    // One chunk of restoring division, most significant bit first
    always_comb begin
        logic [PAD_BITS-1:0] w;
        logic [RADIX_W:0]    t;
        logic [RADIX_W-1:0]  r;
        w = work_reg;
        r = rem_reg;
        for (int k = 0; k < STEP_BITS; k++) begin
            t = {r, w[PAD_BITS-1]};
            w = {w[PAD_BITS-2:0], 1'b0};
            if (t >= {1'b0, radix}) begin
                t    = t - {1'b0, radix};
                w[0] = 1'b1;
            end
            r = t[RADIX_W-1:0];
        end
        work_next = w;
        rem_next  = r;
    end

    // Count down the chunks; flag completion for one cycle
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cyc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= (cyc_reg == CYC_W'(1));
            if (start) begin
                cyc_reg <= CYC_W'(DIV_CYCLES);
            end
            else if (cyc_reg != '0) begin
                cyc_reg <= cyc_reg - CYC_W'(1);
            end
        end
    end

    // Load the dividend or advance the partial quotient and remainder
    always_ff @(posedge clk) begin
        if (start) begin
            work_reg <= {{(PAD_BITS-VALUE_BITS){1'b0}}, dividend};
            rem_reg  <= '0;
        end
        else if (cyc_reg != '0) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign status.busy = (cyc_reg != '0);
    assign status.done = done_reg;
    assign quotient    = work_reg[VALUE_BITS-1:0];
    assign remainder   = rem_reg;

endmodule

`default_nettype wire
